>>> rtl/cosine_range_reduce_polynomial_assert.svh
// assertion macros used by the top level of the cosine pipeline
// no dependencies; each use sits on a line of its own
`ifndef COSINE_RANGE_REDUCE_POLYNOMIAL_ASSERT_SVH
`define COSINE_RANGE_REDUCE_POLYNOMIAL_ASSERT_SVH

// property must hold at every clock edge outside reset
`define CRR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("cosine pipeline assertion failed");

// condition must never be seen at a clock edge outside reset
`define CRR_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("cosine pipeline forbidden condition seen");

`endif

>>> rtl/cosrr_pkg.sv
// types, constants and the coefficient lookup of the cosine pipeline
// no dependencies
package cosrr_pkg;

  // horner accumulator, Q2.30 with headroom
  typedef logic signed [33:0] word_t;
  // reduced angle in Q.52
  typedef logic signed [57:0] q52_t;

  typedef struct packed {
    logic valid;
    logic neg;
  } ctl_t;

  localparam logic signed [31:0] INV_2PI_Q32       = 32'sd683565276;
  localparam q52_t               TWO_PI_Q52        = 58'sh6487ED5110B461;
  localparam q52_t               PI_Q52            = 58'sh3243F6A8885A31;
  localparam q52_t               HALF_PI_Q52       = 58'sh1921FB54442D18;
  localparam q52_t               THREE_HALF_PI_Q52 = 58'sh4B65F1FCCC8749;

  localparam word_t ONE_Q30 = 34'sd1073741824;
  localparam word_t COEF_C1 = 34'sd536870908;
  localparam word_t COEF_C2 = 34'sd44739216;
  localparam word_t COEF_C3 = 34'sd1491255;
  localparam word_t COEF_C4 = 34'sd26587;
  localparam word_t COEF_C5 = 34'sd280;

  localparam int NUM_CELLS    = 5;
  localparam int CELL_IDX_W   = $clog2(NUM_CELLS);
  localparam int REDUCE_DEPTH = 5;
  localparam int LATENCY      = REDUCE_DEPTH + NUM_CELLS + 1;

  // constant added by each horner cell, innermost first
  function automatic word_t cell_coef(input logic [CELL_IDX_W-1:0] idx);
    word_t c;
    case (idx)
      3'd0:    c = COEF_C4;
      3'd1:    c = -COEF_C3;
      3'd2:    c = COEF_C2;
      3'd3:    c = -COEF_C1;
      3'd4:    c = ONE_Q30;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/cosrr_reduce.sv
// range reduction to [0, 2pi), quadrant fold and squaring, five stages
// depends on cosrr_pkg
module cosrr_reduce (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic signed [31:0]  angle_i,
  output cosrr_pkg::ctl_t     ctl_o,
  output logic        [31:0]  x2_o
);

  logic [4:0] valid_q;

  // stage 1: turn count
  logic signed [63:0] prod;
  logic signed [63:0] prod_bias;
  logic signed [5:0]  k_d, k_q;
  logic signed [31:0] ang1_q;

  // stage 2: remainder
  logic signed [61:0] ang_sh;
  logic signed [61:0] kp;
  logic signed [61:0] r_full;
  cosrr_pkg::q52_t    r_d, r_q;

  // stage 3: wrap negative remainder
  cosrr_pkg::q52_t    ra_d, ra_q;

  // stage 4: fold
  cosrr_pkg::q52_t    f;
  cosrr_pkg::q52_t    fm;
  logic               neg_d, neg4_q, neg5_q;
  logic        [30:0] x_d, x_q;

  // stage 5: square
  logic        [61:0] sq;
  logic        [31:0] x2_q;

  always_comb begin
    prod      = 64'(angle_i * cosrr_pkg::INV_2PI_Q32);
    // truncate toward zero
    prod_bias = prod + (prod[63] ? 64'sh00FF_FFFF_FFFF_FFFF : 64'sd0);
    k_d       = prod_bias[61:56];
  end

  always_comb begin
    ang_sh = {{2{ang1_q[31]}}, ang1_q, 28'd0};
    kp     = 62'(k_q * cosrr_pkg::TWO_PI_Q52);
    r_full = ang_sh - kp;
    r_d    = r_full[57:0];
  end

  assign ra_d = r_q[57] ? (r_q + cosrr_pkg::TWO_PI_Q52) : r_q;

  always_comb begin
    if (ra_q < cosrr_pkg::HALF_PI_Q52) begin
      f     = ra_q;
      neg_d = 1'b0;
    end else if (ra_q < cosrr_pkg::PI_Q52) begin
      f     = cosrr_pkg::PI_Q52 - ra_q;
      neg_d = 1'b1;
    end else if (ra_q < cosrr_pkg::THREE_HALF_PI_Q52) begin
      f     = ra_q - cosrr_pkg::PI_Q52;
      neg_d = 1'b1;
    end else begin
      f     = cosrr_pkg::TWO_PI_Q52 - ra_q;
      neg_d = 1'b0;
    end
    // even polynomial, so a slightly negative fold is taken by magnitude
    fm  = f[57] ? -f : f;
    x_d = fm[52:22];
  end

  assign sq = {31'd0, x_q} * {31'd0, x_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    ang1_q <= angle_i;
    r_q    <= r_d;
    ra_q   <= ra_d;
    x_q    <= x_d;
    neg4_q <= neg_d;
    x2_q   <= sq[61:30];
    neg5_q <= neg4_q;
  end

  assign ctl_o.valid = valid_q[4];
  assign ctl_o.neg   = neg5_q;
  assign x2_o        = x2_q;

endmodule

>>> rtl/cosrr_cell.sv
// one horner step: t_out = floor(x2 * t_in / 2^30) + coef, registered
// depends on cosrr_pkg
module cosrr_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cosrr_pkg::ctl_t     ctl_i,
  input  logic        [31:0]  x2_i,
  input  cosrr_pkg::word_t    t_i,
  input  cosrr_pkg::word_t    coef_i,
  output cosrr_pkg::ctl_t     ctl_o,
  output logic        [31:0]  x2_o,
  output cosrr_pkg::word_t    t_o
);

  logic signed [66:0] prod;
  logic signed [36:0] prod_sh;
  cosrr_pkg::word_t   t_d, t_q;
  logic               valid_q;
  logic               neg_q;
  logic        [31:0] x2_q;

  always_comb begin
    prod    = 67'($signed({1'b0, x2_i}) * t_i);
    // arithmetic shift floors toward minus infinity
    prod_sh = prod[66:30];
    t_d     = prod_sh[33:0] + coef_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    neg_q <= ctl_i.neg;
    x2_q  <= x2_i;
  end

  assign ctl_o.valid = valid_q;
  assign ctl_o.neg   = neg_q;
  assign x2_o        = x2_q;
  assign t_o         = t_q;

endmodule

>>> rtl/cosine_range_reduce_polynomial.sv
// top level of the cosine pipeline: reduction stages, a chain of horner cells, output stage
// depends on cosrr_pkg, cosrr_reduce, cosrr_cell and the assertion header
//
// usage:
//   start_i with angle_i (signed Q8.24 radians) hands in one item; it is taken
//   at every rising edge where start_i is high and busy_o is low. busy_o stays
//   low, so a new angle may be given in every cycle.
//   done_o is high for exactly one cycle with cosine_o (signed Q2.30, saturated
//   to [-1, 1]) valid in that same cycle; results come out in input order.
//   the path from the accepting edge to done_o runs through five reduction stages
//   (turn count, remainder, wrap, fold, square), five horner cells each owning one
//   coefficient, and one sign and clamp stage.
//   throughput: one item per cycle, set by the fully registered cell chain.
//   reset (rst_ni low, asynchronous) clears every stage valid bit; items in
//   flight are dropped and no done_o appears until new items arrive.
//   the receiver cannot stall; each result is shown once and not held.
`include "cosine_range_reduce_polynomial_assert.svh"

module cosine_range_reduce_polynomial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] angle_i,
  output logic               busy_o,
  output logic               done_o,
  output logic signed [31:0] cosine_o
);

  // one in Q2.30, the largest magnitude a result may have
  localparam logic signed [31:0] COS_ONE = 32'sd1073741824;

  logic                     accept;
  cosrr_pkg::ctl_t          ctl   [cosrr_pkg::NUM_CELLS+1];
  logic             [31:0]  x2    [cosrr_pkg::NUM_CELLS+1];
  cosrr_pkg::word_t         t     [cosrr_pkg::NUM_CELLS+1];
  cosrr_pkg::word_t         res_s;
  logic signed      [31:0]  cos_d, cos_q;
  logic                     done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  cosrr_reduce u_reduce (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .angle_i (angle_i),
    .ctl_o   (ctl[0]),
    .x2_o    (x2[0])
  );

  // innermost term of the polynomial
  assign t[0] = -cosrr_pkg::COEF_C5;

  for (genvar i = 0; i < cosrr_pkg::NUM_CELLS; i++) begin : g_cell
    cosrr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[i]),
      .x2_i   (x2[i]),
      .t_i    (t[i]),
      .coef_i (cosrr_pkg::cell_coef(cosrr_pkg::CELL_IDX_W'(i))),
      .ctl_o  (ctl[i+1]),
      .x2_o   (x2[i+1]),
      .t_o    (t[i+1])
    );
  end

  always_comb begin
    res_s = ctl[cosrr_pkg::NUM_CELLS].neg ? -t[cosrr_pkg::NUM_CELLS]
                                          : t[cosrr_pkg::NUM_CELLS];
    if (res_s > cosrr_pkg::ONE_Q30) begin
      cos_d = 32'(cosrr_pkg::ONE_Q30);
    end else if (res_s < -cosrr_pkg::ONE_Q30) begin
      cos_d = -32'(cosrr_pkg::ONE_Q30);
    end else begin
      cos_d = res_s[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctl[cosrr_pkg::NUM_CELLS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    cos_q <= cos_d;
  end

  assign done_o   = done_q;
  assign cosine_o = cos_q;

  // every result traces back to an item that was accepted earlier
  `CRR_ASSERT(a_done_latency, clk_i, rst_ni, done_o |-> $past(accept, cosrr_pkg::LATENCY))
  // clamp keeps the result within [-1, 1]
  `CRR_ASSERT(a_cos_range, clk_i, rst_ni, done_o |-> (cosine_o <= COS_ONE && cosine_o >= -COS_ONE))
  // the squared fold is below pi^2/4 in Q2.30, so it never reaches 3.0
  `CRR_ASSERT_NEVER(a_x2_bound, clk_i, rst_ni, ctl[0].valid && x2[0] >= 32'd3221225472)
  // the pipeline never stalls intake
  `CRR_ASSERT_NEVER(a_never_busy, clk_i, rst_ni, busy_o)

endmodule

>>> bench/testbench.sv
// self-checking bench for the cosine pipeline: directed angle table, then random bursts
// expected cosines come from a bit-exact fixed-point predictor kept in this file
// depends on cosrr_pkg (pipeline latency) and the cosine_range_reduce_polynomial top level
`timescale 1ns / 1ps

module testbench;

  // fixed-point constants of the reduction and the polynomial
  localparam longint INV_TWO_PI_Q32  = 64'sd683565276;
  localparam longint TWO_PI_Q52      = 64'sh6487ED5110B461;
  localparam longint PI_Q52          = 64'sh3243F6A8885A31;
  localparam longint HALF_PI_Q52     = 64'sh1921FB54442D18;
  localparam longint THREE_HALF_Q52  = 64'sh4B65F1FCCC8749;
  localparam longint UNITY_Q30       = 64'sd1073741824;
  localparam longint TAYLOR_C1       = 64'sd536870908;
  localparam longint TAYLOR_C2       = 64'sd44739216;
  localparam longint TAYLOR_C3       = 64'sd1491255;
  localparam longint TAYLOR_C4       = 64'sd26587;
  localparam longint TAYLOR_C5       = 64'sd280;

  localparam int HALF_PI_Q24   = 26353589;
  localparam int RANDOM_ANGLES = 900;
  localparam int NUM_VECTORS   = 22;

  typedef struct packed {
    logic signed [31:0] angle;
    logic               known;
    logic signed [31:0] cosine;
  } angle_vec_t;

  // rows with known set carry a hand-read cosine, the rest go through the predictor
  localparam angle_vec_t ANGLE_TABLE [NUM_VECTORS] = '{
    '{32'sd0,           1'b1, 32'sd1073741824},
    '{32'sd1,           1'b0, 32'sd0},
    '{-32'sd1,          1'b0, 32'sd0},
    '{32'sd16,          1'b0, 32'sd0},
    '{32'sh7FFFFFFF,    1'b0, 32'sd0},
    '{32'sh80000000,    1'b0, 32'sd0},
    '{32'sh80000001,    1'b0, 32'sd0},
    '{32'sd26353589,    1'b0, 32'sd0},
    '{-32'sd26353589,   1'b0, 32'sd0},
    '{32'sd52707179,    1'b0, 32'sd0},
    '{-32'sd52707179,   1'b0, 32'sd0},
    '{32'sd79060768,    1'b0, 32'sd0},
    '{32'sd105414357,   1'b0, 32'sd0},
    '{32'sd105414358,   1'b0, 32'sd0},
    '{-32'sd105414357,  1'b0, 32'sd0},
    '{32'sd2108287146,  1'b0, 32'sd0},
    '{-32'sd2108287146, 1'b0, 32'sd0},
    '{32'sd2108287140,  1'b0, 32'sd0},
    '{32'sh40000000,    1'b0, 32'sd0},
    '{32'sh7FFF0000,    1'b0, 32'sd0},
    '{32'sh00FFFFFF,    1'b0, 32'sd0},
    '{32'sh55555555,    1'b0, 32'sd0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic signed [31:0] angle_i;
  logic               busy_o;
  logic               done_o;
  logic signed [31:0] cosine_o;

  logic signed [31:0] cosine_want;
  logic signed [31:0] cosine_queue [$];
  logic signed [31:0] oldest_cosine;
  int                 n_taken;
  int                 mismatches;

  cosine_range_reduce_polynomial u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .angle_i  (angle_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .cosine_o (cosine_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Q2.30 product, floor toward minus infinity
  function automatic longint mul_q30(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic logic signed [31:0] cosine_of(input logic signed [31:0] angle);
    longint rad, turns, prod, rem, fold, x, x2, acc;
    logic   negate;
    rad    = angle;
    negate = 1'b0;
    prod   = rad * INV_TWO_PI_Q32;
    turns  = (prod >= 0) ? (prod >>> 56) : -((-prod) >>> 56);
    rem    = (rad <<< 28) - turns * TWO_PI_Q52;
    if (rem < 0) rem = rem + TWO_PI_Q52;
    if (rem < HALF_PI_Q52) begin
      fold = rem;
    end else if (rem < PI_Q52) begin
      fold   = PI_Q52 - rem;
      negate = 1'b1;
    end else if (rem < THREE_HALF_Q52) begin
      fold   = rem - PI_Q52;
      negate = 1'b1;
    end else begin
      fold = TWO_PI_Q52 - rem;
    end
    // last quadrant may fold slightly below zero, polynomial is even
    if (fold < 0) fold = -fold;
    x   = fold >>> 22;
    x2  = (x * x) >>> 30;
    acc = mul_q30(x2, -TAYLOR_C5) + TAYLOR_C4;
    acc = mul_q30(x2, acc) - TAYLOR_C3;
    acc = mul_q30(x2, acc) + TAYLOR_C2;
    acc = mul_q30(x2, acc) - TAYLOR_C1;
    acc = UNITY_Q30 + mul_q30(x2, acc);
    if (negate) acc = -acc;
    if (acc > UNITY_Q30) acc = UNITY_Q30;
    if (acc < -UNITY_Q30) acc = -UNITY_Q30;
    return acc[31:0];
  endfunction

  function automatic logic signed [31:0] random_angle();
    int q;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6, 7: begin
        // close to a quadrant boundary, multiples of 2pi included
        q = $urandom_range(0, 162) - 81;
        return q * HALF_PI_Q24 + $urandom_range(0, 64) - 32;
      end
      8: return $urandom_range(0, 1) ? $urandom_range(0, 4096) : -$urandom_range(0, 4096);
      default: begin
        if ($urandom_range(0, 1)) return 32'sh7FFFFFFF - $urandom_range(0, 255);
        return 32'sh80000000 + $urandom_range(0, 255);
      end
    endcase
  endfunction

  // hold the item until the monitor has seen it taken
  task automatic send_angle(input logic signed [31:0] angle, input logic signed [31:0] want);
    int target;
    target      = n_taken + 1;
    start_i     = 1'b1;
    angle_i     = angle;
    cosine_want = want;
    do @(negedge clk_i); while (n_taken < target);
  endtask

  task automatic idle_for(input int cycles);
    start_i = 1'b0;
    angle_i = $urandom;
    repeat (cycles) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (cosine_queue.size() == 0) begin
          $display("%0t unexpected cosine: expected none, actual %0d", $time, cosine_o);
          mismatches++;
        end else begin
          oldest_cosine = cosine_queue.pop_front();
          if (cosine_o !== oldest_cosine) begin
            $display("%0t cosine mismatch: expected %0d, actual %0d",
                     $time, oldest_cosine, cosine_o);
            mismatches++;
          end
        end
      end
      if (start_i && !busy_o) begin
        cosine_queue.push_back(cosine_want);
        n_taken++;
      end
    end
  end

  initial begin
    int sent;
    int burst;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    angle_i     = '0;
    cosine_want = '0;
    n_taken     = 0;
    mismatches  = 0;
    sent        = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NUM_VECTORS; i++) begin
      send_angle(ANGLE_TABLE[i].angle,
                 ANGLE_TABLE[i].known ? ANGLE_TABLE[i].cosine
                                      : cosine_of(ANGLE_TABLE[i].angle));
    end
    idle_for(3);

    while (sent < RANDOM_ANGLES) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst; j++) begin
        logic signed [31:0] a;
        a = random_angle();
        send_angle(a, cosine_of(a));
        sent++;
      end
      // some bursts run straight into the next one
      if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
    end
    start_i = 1'b0;

    while (cosine_queue.size() != 0) @(negedge clk_i);
    repeat (cosrr_pkg::LATENCY + 4) @(negedge clk_i);
    if (cosine_queue.size() != 0) mismatches++;

    if (mismatches == 0) begin
      $display("PASS cosine_range_reduce_polynomial");
    end else begin
      $display("FAIL cosine_range_reduce_polynomial");
    end
    $finish;
  end

  initial begin
    #200us;
    $display("FAIL cosine_range_reduce_polynomial");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/cosrr_pkg.sv
rtl/cosrr_reduce.sv
rtl/cosrr_cell.sv
rtl/cosine_range_reduce_polynomial.sv
bench/testbench.sv
